FILE: sv/etqa_pkg.sv
// Shared types and codes for the event time queue.
// No dependencies.
package etqa_pkg;
	localparam int TIME_BITS = 48;

	typedef enum logic [1:0] {
		CMD_SCHED_ABS = 2'd0,
		CMD_SCHED_REL = 2'd1,
		CMD_ADVANCE   = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FINISHED = 2'd1,
		ST_INVALID  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	localparam logic REG_MAX_STEP = 1'b0;
	localparam logic REG_SMOOTH   = 1'b1;
	localparam logic [31:0] MAX_STEP_RESET = 32'd6554;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_POP,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, start scan
		logic scan_step; // read one entry, fold the previous one in
		logic decide;    // act on scan result
		logic pop_move;  // move the last entry into the popped slot
		logic finish;    // load output registers
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic need_pop;
	} dp_stat_t;
endpackage

FILE: sv/event_time_queue_advance.sv
// Discrete-event time queue: event times kept unsorted in one memory, a sequencer
// and a datapath. A request passes through load, one scan step per entry plus one,
// decide, an optional pop and the result load; clear skips the scan. One request at
// a time: the next is taken in the cycle after the result loads, later while a result
// waits on out_ready.
// Reset clears time, pending time and count; max_step 6554 (0.1), smoothing on.
module event_time_queue_advance #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [etqa_pkg::TIME_BITS-1:0] time_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [etqa_pkg::TIME_BITS-1:0] current_time,
	output logic [etqa_pkg::TIME_BITS-1:0] latest_scheduled_time,
	output logic                          event_announced,
	output logic [etqa_pkg::TIME_BITS-1:0] announced_time,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [31:0]                   cfg_index,
	input  logic [31:0]                   cfg_data
);
	import etqa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Config writes are always taken; indexes beyond the list do nothing.
	assign cfg_ready = 1'b1;

	etqa_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	etqa_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk, .arst_n, .command, .time_value,
		.cfg_valid, .cfg_index(cfg_index[0]),
		.cfg_index_ok(cfg_index[31:1] == '0), .cfg_data,
		.cmd, .stat, .status, .current_time, .latest_scheduled_time,
		.event_announced, .announced_time
	);
endmodule

FILE: sv/etqa_ctrl.sv
// Sequencer for the event time queue: scan, decide, pop, respond.
// Depends on etqa_pkg.
module etqa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  etqa_pkg::dp_stat_t stat,
	output etqa_pkg::dp_cmd_t  cmd
);
	import etqa_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.scan_done) begin
					cmd.scan_step = 1'b1;
				end else begin
					cmd.decide = 1'b1;
					if (stat.need_pop) state_d = S_POP;
					else               state_d = S_DONE;
				end
			end
			S_POP: begin
				cmd.pop_move = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: sv/etqa_dp.sv
// Datapath for the event time queue: clock registers, event memory, result registers.
// Depends on etqa_pkg.
module etqa_dp #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    command,
	input  logic [etqa_pkg::TIME_BITS-1:0] time_value,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic                          cfg_index_ok,
	input  logic [31:0]                   cfg_data,
	input  etqa_pkg::dp_cmd_t             cmd,
	output etqa_pkg::dp_stat_t            stat,
	output logic [1:0]                    status,
	output logic [etqa_pkg::TIME_BITS-1:0] current_time,
	output logic [etqa_pkg::TIME_BITS-1:0] latest_scheduled_time,
	output logic                          event_announced,
	output logic [etqa_pkg::TIME_BITS-1:0] announced_time
);
	import etqa_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// Entries below count_q are live, in no particular order.
	logic [TIME_BITS-1:0] mem [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] rd_q;

	logic [31:0]          max_step_q;
	logic                 smooth_q;
	logic [TIME_BITS-1:0] now_q, pend_q, latest_q, t_q, min_q;
	logic [CW-1:0]        count_q, ptr_q;
	logic [AW-1:0]        idx_q, min_idx_q;
	cmd_t                 cmd_q;
	status_t              st_q;
	logic                 ann_q, bad_q, rd_ok_q, found_q, stop_q;

	logic [TIME_BITS:0]   rel_sum;
	logic [TIME_BITS-1:0] gap, pop_gap, step_ext;
	logic                 big_gap, pop_big, adv_idle, pop_now;
	logic                 is_sched, sched_live, sched_dup, sched_new;
	logic [AW-1:0]        last_idx;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [TIME_BITS-1:0] mem_wd;

	assign rel_sum  = {1'b0, now_q} + {1'b0, time_value};
	assign step_ext = TIME_BITS'(max_step_q);
	assign gap      = pend_q - now_q;
	assign big_gap  = smooth_q && (pend_q > now_q) && (gap > step_ext);
	assign adv_idle = !big_gap && !(now_q < pend_q);
	assign pop_now  = (cmd_q == CMD_ADVANCE) && adv_idle && (count_q != '0);
	assign pop_gap  = min_q - now_q;
	assign pop_big  = smooth_q && (min_q > now_q) && (pop_gap > step_ext);
	assign last_idx = AW'(count_q - CW'(1));

	assign is_sched   = (cmd_q == CMD_SCHED_ABS) || (cmd_q == CMD_SCHED_REL);
	assign sched_live = is_sched && !bad_q && (t_q > now_q);
	assign sched_dup  = sched_live && found_q;
	assign sched_new  = sched_live && !found_q && (count_q != CW'(QUEUE_DEPTH));

	assign stat.scan_done = stop_q;
	assign stat.need_pop  = pop_now;

	// One memory write port: append on insert, slot zero on clear, refill on pop.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		if (cmd.decide && sched_new) begin
			mem_we = 1'b1;
			mem_wa = count_q[AW-1:0];
			mem_wd = t_q;
		end else if (cmd.decide && cmd_q == CMD_CLEAR) begin
			mem_we = 1'b1;
		end else if (cmd.pop_move) begin
			mem_we = 1'b1;
			mem_wa = min_idx_q;
			mem_wd = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.scan_step && ptr_q != count_q) rd_q <= mem[ptr_q[AW-1:0]];
		else if (cmd.decide && pop_now)       rd_q <= mem[last_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= MAX_STEP_RESET;
			smooth_q   <= 1'b1;
			now_q      <= '0;
			pend_q     <= '0;
			latest_q   <= '0;
			count_q    <= '0;
			cmd_q      <= CMD_SCHED_ABS;
			st_q       <= ST_OK;
			t_q        <= '0;
			min_q      <= '0;
			ptr_q      <= '0;
			idx_q      <= '0;
			min_idx_q  <= '0;
			ann_q      <= 1'b0;
			bad_q      <= 1'b0;
			rd_ok_q    <= 1'b0;
			found_q    <= 1'b0;
			stop_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index_ok) begin
				if (cfg_index == REG_MAX_STEP) max_step_q <= cfg_data;
				else                           smooth_q   <= cfg_data[0];
			end
			if (cmd.load) begin
				cmd_q     <= cmd_t'(command);
				ptr_q     <= '0;
				rd_ok_q   <= 1'b0;
				found_q   <= 1'b0;
				min_q     <= '1;
				min_idx_q <= '0;
				// clear needs no scan
				stop_q    <= (command == CMD_CLEAR);
				if (command == CMD_SCHED_REL) begin
					t_q   <= rel_sum[TIME_BITS-1:0];
					bad_q <= (time_value == '0) || rel_sum[TIME_BITS];
				end else begin
					t_q   <= time_value;
					bad_q <= 1'b0;
				end
			end
			// Scan: issue a read per step, fold the entry read last step.
			if (cmd.scan_step) begin
				if (rd_ok_q) begin
					if (rd_q == t_q) found_q <= 1'b1;
					if (rd_q < min_q) begin
						min_q     <= rd_q;
						min_idx_q <= idx_q;
					end
				end
				if (ptr_q != count_q) begin
					rd_ok_q <= 1'b1;
					idx_q   <= ptr_q[AW-1:0];
					ptr_q   <= ptr_q + CW'(1);
				end else begin
					rd_ok_q <= 1'b0;
					stop_q  <= 1'b1;
				end
			end
			if (cmd.decide) begin
				ann_q <= sched_dup || sched_new;
				if (is_sched) begin
					if (bad_q || t_q < now_q) st_q <= ST_INVALID;
					else if (sched_live && !found_q && !sched_new) st_q <= ST_FULL;
					else st_q <= ST_OK;
					if ((sched_dup || sched_new) && pend_q > t_q) pend_q <= t_q;
					if (sched_new) begin
						count_q <= count_q + CW'(1);
						if (t_q > latest_q) latest_q <= t_q;
					end
				end else if (cmd_q == CMD_ADVANCE) begin
					st_q <= (adv_idle && count_q == '0) ? ST_FINISHED : ST_OK;
					if (big_gap)             now_q <= now_q + step_ext;
					else if (now_q < pend_q) now_q <= pend_q;
					else if (pop_now) begin
						pend_q  <= min_q;
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) latest_q <= '0;
						if (pop_big) now_q <= now_q + step_ext;
						else         now_q <= min_q;
					end
				end else begin
					st_q     <= ST_OK;
					now_q    <= '0;
					pend_q   <= '0;
					latest_q <= '0;
					count_q  <= CW'(1);
				end
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status                <= st_q;
			current_time          <= now_q;
			latest_scheduled_time <= latest_q;
			event_announced       <= ann_q;
			announced_time        <= ann_q ? t_q : '0;
		end
	end
endmodule

FILE: tb/etqa_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the event time queue: watches the request, result and register channels.
// Depends on etqa_pkg for command and status codes.
module etqa_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [47:0] time_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [47:0] current_time,
	input  logic [47:0] latest_scheduled_time,
	input  logic        event_announced,
	input  logic [47:0] announced_time,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          awaited_count
);
	import etqa_pkg::*;

	localparam int DEPTH = 64;

	typedef struct {
		status_t     st;
		logic [47:0] now;
		logic [47:0] latest;
		logic        ann;
		logic [47:0] ann_time;
	} clock_report_t;

	logic [31:0] step_limit;
	logic        smooth_on;
	logic [47:0] now_t;
	logic [47:0] next_t;
	logic [47:0] event_times[$];
	clock_report_t reports_due[$];
	int errors;

	assign fail_count    = errors;
	assign awaited_count = reports_due.size();

	task automatic insert_event(input logic [47:0] t, output status_t st, output logic ann);
		int pos;
		begin
			pos = 0;
			ann = 1'b0;
			st  = ST_OK;
			if (t < now_t) begin
				st = ST_INVALID;
			end else if (t != now_t) begin
				while (pos < event_times.size() && event_times[pos] < t) pos++;
				if (pos < event_times.size() && event_times[pos] == t) begin
					if (next_t > t) next_t = t;
					ann = 1'b1;
				end else if (event_times.size() >= DEPTH) begin
					st = ST_FULL;
				end else begin
					event_times.insert(pos, t);
					if (next_t > t) next_t = t;
					ann = 1'b1;
				end
			end
		end
	endtask

	task automatic advance_clock(output status_t st);
		begin
			st = ST_OK;
			if (smooth_on && next_t > now_t && (next_t - now_t) > {16'd0, step_limit}) begin
				now_t = now_t + step_limit;
			end else if (now_t < next_t) begin
				now_t = next_t;
			end else if (event_times.size() == 0) begin
				st = ST_FINISHED;
			end else begin
				next_t = event_times.pop_front();
				if (smooth_on && next_t > now_t &&
					(next_t - now_t) > {16'd0, step_limit})
					now_t = now_t + step_limit;
				else
					now_t = next_t;
			end
		end
	endtask

	task automatic predict_report(input cmd_t cmd, input logic [47:0] tv);
		clock_report_t r;
		logic [48:0] sum;
		logic [47:0] t;
		begin
			r.ann = 1'b0;
			r.st  = ST_OK;
			t = '0;
			case (cmd)
				CMD_SCHED_ABS: begin
					t = tv;
					insert_event(t, r.st, r.ann);
				end
				CMD_SCHED_REL: begin
					sum = {1'b0, now_t} + {1'b0, tv};
					t = sum[47:0];
					if (tv == '0 || sum[48]) r.st = ST_INVALID;
					else insert_event(t, r.st, r.ann);
				end
				CMD_ADVANCE: advance_clock(r.st);
				default: begin
					now_t  = '0;
					next_t = '0;
					event_times = {48'd0};
				end
			endcase
			r.now      = now_t;
			r.latest   = event_times.size() ? event_times[$] : '0;
			r.ann_time = r.ann ? t : '0;
			reports_due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		clock_report_t e;
		if (!arst_n) begin
			step_limit = MAX_STEP_RESET;
			smooth_on  = 1'b1;
			now_t      = '0;
			next_t     = '0;
			event_times = {};
			reports_due = {};
			errors     = 0;
		end else begin
			// compare results first: a result never belongs to a request taken on the same edge
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					errors++;
					if (errors <= 10) $display("%0t: unexpected result status=%0d", $realtime, status);
				end else begin
					e = reports_due.pop_front();
					if (status != e.st || current_time != e.now ||
						latest_scheduled_time != e.latest || event_announced != e.ann ||
						announced_time != e.ann_time) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch exp st=%0d now=%h last=%h ann=%b at=%h got st=%0d now=%h last=%h ann=%b at=%h",
								$realtime, e.st, e.now, e.latest, e.ann, e.ann_time,
								status, current_time, latest_scheduled_time,
								event_announced, announced_time);
					end
				end
			end
			if (in_valid && in_ready) predict_report(cmd_t'(command), time_value);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 32'(REG_MAX_STEP)) step_limit = cfg_data;
				else if (cfg_index == 32'(REG_SMOOTH)) smooth_on = cfg_data[0];
			end
		end
	end
endmodule

FILE: tb/tb_event_time_queue_advance.sv
`timescale 1ns / 1ps
// Top of the event time queue testbench: clock, reset, stimulus and verdict.
// Depends on etqa_pkg, event_time_queue_advance and etqa_checker.
module tb_event_time_queue_advance;
	import etqa_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [47:0] time_value;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [47:0] current_time;
	logic [47:0] latest_scheduled_time;
	logic        event_announced;
	logic [47:0] announced_time;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_index;
	logic [31:0] cfg_data;
	int          fail_count;
	int          awaited_count;

	// receiver control: hold_req asks for one long stall, counted by the receiver itself
	logic hold_req;
	int   burst_left;

	event_time_queue_advance u_top (.*);

	etqa_checker u_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drop ready on a changing pattern; hold it low for a long stretch on request.
	initial begin : receiver
		int mode;
		int left;
		mode = 0;
		left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 300);
			end
			left--;
			case (mode)
				0: out_ready = 1'b1;
				1: out_ready = ($urandom_range(0, 1) == 1);
				2: out_ready = ($urandom_range(0, 3) == 0);
				default: out_ready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Offer one request and hold it until it is taken.
	task automatic send_request(input cmd_t cmd, input logic [47:0] tv);
		begin
			@(negedge clk);
			in_valid   = 1'b1;
			command    = cmd;
			time_value = tv;
			do @(posedge clk); while (!in_ready);
			// close the burst with a random gap
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
				burst_left = $urandom_range(0, 12);
			end
		end
	endtask

	// Wait until every result has arrived, then let the block settle.
	task automatic drain;
		begin
			@(negedge clk);
			in_valid = 1'b0;
			while (awaited_count != 0) @(posedge clk);
			repeat (150) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [31:0] idx, input logic [31:0] val);
		begin
			@(negedge clk);
			cfg_valid = 1'b1;
			cfg_index = idx;
			cfg_data  = val;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
			cfg_valid = 1'b0;
		end
	endtask

	function automatic logic [47:0] wide_random();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Mostly small deltas near now so that events are reached; some wide noise.
	task automatic random_request(input int sched_weight);
		int pick;
		logic [47:0] tv;
		begin
			pick = $urandom_range(0, 99);
			if (pick < sched_weight / 2) begin
				case ($urandom_range(0, 9))
					0: tv = '0;
					1: tv = wide_random();
					default: tv = 48'($urandom_range(1, 40000));
				endcase
				send_request(CMD_SCHED_REL, tv);
			end else if (pick < sched_weight) begin
				if ($urandom_range(0, 9) == 0) tv = wide_random();
				else tv = 48'($urandom_range(0, 1 << 22));
				send_request(CMD_SCHED_ABS, tv);
			end else if (pick < 97) begin
				send_request(CMD_ADVANCE, wide_random());
			end else begin
				send_request(CMD_CLEAR, wide_random());
			end
		end
	endtask

	initial begin : stimulus
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_ADVANCE;
		time_value = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		hold_req   = 1'b0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty queue, equal-to-now, duplicates, lowering, past, zero delta, overflow
		send_request(CMD_ADVANCE, '0);
		send_request(CMD_SCHED_ABS, '0);
		send_request(CMD_SCHED_ABS, 48'hFFFF_FFFF_FFFF);
		send_request(CMD_SCHED_REL, 48'hFFFF_FFFF_FFFF);
		send_request(CMD_SCHED_ABS, 48'd100000);
		send_request(CMD_SCHED_ABS, 48'd50000);
		send_request(CMD_SCHED_ABS, 48'd100000);
		send_request(CMD_SCHED_REL, 48'd0);
		send_request(CMD_SCHED_REL, 48'd10);
		repeat (6) send_request(CMD_ADVANCE, '0);
		send_request(CMD_SCHED_ABS, 48'd1);
		send_request(CMD_SCHED_REL, 48'hFFFF_FFFF_FFFF);
		send_request(CMD_CLEAR, 48'hFFFF_FFFF_FFFF);
		send_request(CMD_ADVANCE, '0);
		send_request(CMD_ADVANCE, '0);
		drain();

		// phases over register settings, the extremes among them
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_reg(32'(REG_MAX_STEP), 32'hFFFF_FFFF);
				1: write_reg(32'(REG_SMOOTH), 32'hFFFF_FFFE);
				2: write_reg(32'(REG_MAX_STEP), 32'd0);
				3: write_reg(32'(REG_SMOOTH), 32'd1);
				4: write_reg(32'(REG_MAX_STEP), $urandom_range(1, 100000));
				5: write_reg(32'd5, $urandom);
				6: write_reg(32'(REG_MAX_STEP), MAX_STEP_RESET);
				default: write_reg(32'(REG_SMOOTH), $urandom);
			endcase
			// phase 3 fills the queue to see the full status
			for (int i = 0; i < 210; i++) begin
				random_request(ph == 3 ? 92 : 55);
				if (i == 100 && (ph == 1 || ph == 5)) hold_req = 1'b1;
				if (i == 150 && ph == 4) drain();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("event_time_queue_advance verification clean");
		end else begin
			$display("event_time_queue_advance verification failed");
		end
		$finish;
	end

	initial begin : watchdog
		#50ms;
		$display("event_time_queue_advance verification failed");
		$finish;
	end
endmodule
